>>> rtl/compressed_uint_stream_decoder_core_assert.svh
// Assertion macros shared by the decoder sources.
`ifndef COMPRESSED_UINT_STREAM_DECODER_CORE_ASSERT_SVH
`define COMPRESSED_UINT_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CUSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CUSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cusd_pkg.sv
package cusd_pkg;

    // Field widths of the byte and result channels.
    localparam int BYTE_W     = 8;
    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 29;
    localparam int LEN_W      = 3;
    localparam int TABLE_W    = 6;
    localparam int ROW_W      = 30;
    localparam int LEFT_W     = 2;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr bit 2.
    localparam logic REG_FF_GIVES_ZERO = 1'b0;

    // Stream byte codes.
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'hFF;
    localparam logic [1:0]        PREFIX_TWO  = 2'b10;

    // Entry lengths in bytes.
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // Bytes still expected after the first byte.
    localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    // Token table selectors and identifiers.
    localparam logic [1:0] SEL_TYPEDEF  = 2'd0;
    localparam logic [1:0] SEL_TYPEREF  = 2'd1;
    localparam logic [1:0] SEL_TYPESPEC = 2'd2;
    localparam logic [TABLE_W-1:0] TBL_TYPEDEF  = 6'h02;
    localparam logic [TABLE_W-1:0] TBL_TYPEREF  = 6'h01;
    localparam logic [TABLE_W-1:0] TBL_TYPESPEC = 6'h1B;
    localparam logic [TABLE_W-1:0] TBL_NONE     = 6'h00;

    typedef struct packed {
        logic ff_gives_zero;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   entry_bytes;
        logic               is_token;
        logic [TABLE_W-1:0] tbl_code;
        logic [ROW_W-1:0]   row_index;
    } t_result;

    // Map the low two value bits of a token to its table.
    function automatic logic [TABLE_W-1:0] token_table(input logic [1:0] sel);
        logic [TABLE_W-1:0] id;
        case (sel)
            SEL_TYPEDEF:  id = TBL_TYPEDEF;
            SEL_TYPEREF:  id = TBL_TYPEREF;
            SEL_TYPESPEC: id = TBL_TYPESPEC;
            default:      id = TBL_NONE;
        endcase
        return id;
    endfunction

endpackage

>>> rtl/cusd_if.sv
// Byte request channel.
interface cusd_in_if;
    import cusd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              mode;

    modport source (output valid, output byte_in, output mode, input ready);
    modport sink   (input valid, input byte_in, input mode, output ready);
endinterface

// Decoded entry channel.
interface cusd_out_if;
    import cusd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   entry_bytes;
    logic               is_token;
    logic [TABLE_W-1:0] tbl_code;
    logic [ROW_W-1:0]   row_index;

    modport source (output valid, output value, output entry_bytes, output is_token,
                    output tbl_code, output row_index, input ready);
    modport sink   (input valid, input value, input entry_bytes, input is_token,
                    input tbl_code, input row_index, output ready);
endinterface

>>> rtl/cusd_cfg.sv
module cusd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [cusd_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [cusd_pkg::APB_DATA_W-1:0] i_pwdata,
    output logic [cusd_pkg::APB_DATA_W-1:0] o_prdata,
    output logic                          o_pready,
    output cusd_pkg::t_cfg                o_cfg
);
    import cusd_pkg::*;

    logic r_ff_gives_zero;
    logic n_ff_gives_zero;
    logic reg_hit;

    // Word index of the addressed register.
    assign reg_hit = (i_paddr[2] == REG_FF_GIVES_ZERO);

    // Register write on the access phase.
    always_comb begin
        n_ff_gives_zero = r_ff_gives_zero;
        if (i_psel && i_penable && i_pwrite && reg_hit) begin
            n_ff_gives_zero = i_pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_gives_zero <= 1'b1;
        end else begin
            r_ff_gives_zero <= n_ff_gives_zero;
        end
    end

    // Read data and the always-ready response.
    assign o_prdata = reg_hit ? {{(APB_DATA_W-1){1'b0}}, r_ff_gives_zero}
                              : {APB_DATA_W{1'b0}};
    assign o_pready = 1'b1;
    assign o_cfg.ff_gives_zero = r_ff_gives_zero;

endmodule

>>> rtl/cusd_decode.sv
module cusd_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [cusd_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_mode,
    input  cusd_pkg::t_cfg              i_cfg,
    output logic                        o_res_valid,
    output cusd_pkg::t_result           o_res
);
    import cusd_pkg::*;

    logic [LEFT_W-1:0] r_bytes_left;
    logic [LEFT_W-1:0] n_bytes_left;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic              r_token;
    logic              n_token;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;

    logic               done;
    logic [VALUE_W-1:0] val;
    logic [LEN_W-1:0]   len;
    logic               tok;
    logic [ACC_W-1:0]   acc_shift;

    // Entry assembly: one byte per request.
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_token      = r_token;
        n_len        = r_len;
        done         = 1'b0;
        val          = {VALUE_W{1'b0}};
        len          = LEN_ONE;
        tok          = i_mode;
        acc_shift    = {r_acc[ACC_W-BYTE_W-1:0], i_byte};
        if (r_bytes_left == LEFT_NONE) begin
            if (!i_byte[BYTE_W-1]) begin
                // Single-byte value.
                done = 1'b1;
                val  = {{(VALUE_W-BYTE_W){1'b0}}, i_byte};
            end else if (i_byte == ESCAPE_BYTE) begin
                // The escape byte is zero in token mode or when configured so.
                done = 1'b1;
                val  = (i_mode || i_cfg.ff_gives_zero) ? {VALUE_W{1'b0}} : {VALUE_W{1'b1}};
            end else if (i_byte[BYTE_W-1:BYTE_W-2] == PREFIX_TWO) begin
                n_token      = i_mode;
                n_acc        = {{(ACC_W-6){1'b0}}, i_byte[5:0]};
                n_bytes_left = LEFT_ONE;
                n_len        = LEN_TWO;
            end else begin
                n_token      = i_mode;
                n_acc        = {{(ACC_W-5){1'b0}}, i_byte[4:0]};
                n_bytes_left = LEFT_THREE;
                n_len        = LEN_FOUR;
            end
        end else begin
            // Continuation byte, most significant first.
            n_acc        = acc_shift;
            n_bytes_left = r_bytes_left - LEFT_ONE;
            if (r_bytes_left == LEFT_ONE) begin
                done = 1'b1;
                val  = {{(VALUE_W-ACC_W){1'b0}}, acc_shift};
                len  = r_len;
                tok  = r_token;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= LEFT_NONE;
            r_acc        <= {ACC_W{1'b0}};
            r_token      <= 1'b0;
            r_len        <= {LEN_W{1'b0}};
        end else if (i_accept) begin
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_token      <= n_token;
            r_len        <= n_len;
        end
    end

    // Result formatting, with the token split in token mode.
    assign o_res_valid       = i_accept && done;
    assign o_res.value       = val;
    assign o_res.entry_bytes = len;
    assign o_res.is_token    = tok;
    assign o_res.tbl_code    = tok ? token_table(val[1:0]) : TBL_NONE;
    assign o_res.row_index   = tok ? val[VALUE_W-1:2] : {ROW_W{1'b0}};

endmodule

>>> rtl/cusd_skid.sv
module cusd_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cusd_pkg::t_result i_data,
    output logic              o_can_push,
    output logic              o_valid,
    output cusd_pkg::t_result o_data,
    input  logic              i_ready
);
    import cusd_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    main_free;

    // The output slot can load when it is empty or being taken.
    assign main_free = !r_main_valid || i_ready;

    // Control: pushes arrive only while the spare slot is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload moves.
    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main;

endmodule

>>> rtl/compressed_uint_stream_decoder_core.sv
// Compressed unsigned integer stream decoder. One stream byte is taken per
// clock cycle while input ready is high; an entry of one, two or four bytes
// yields one result, decoded by a single pass of mask, shift and compare logic
// between the entry state registers and the output buffer registers.
// The output side has a two-slot buffer, so bytes keep flowing while a result
// waits and input ready drops only when both slots hold results. The escape
// byte 0xFF decodes to zero or all ones per the ff_gives_zero register
// (address 0, reset 1), and always to zero in token mode.
`include "compressed_uint_stream_decoder_core_assert.svh"

module compressed_uint_stream_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cusd_in_if.sink                         i_in,
    cusd_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cusd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cusd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cusd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cusd_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result out_data;
    logic    res_valid;
    logic    can_push;
    logic    accept;
    logic    len_legal;
    logic    plain_ok;

    // Configuration registers.
    cusd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    // Byte request handshake.
    assign i_in.ready = can_push;
    assign accept     = i_in.valid && can_push;

    cusd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in.byte_in),
        .i_mode      (i_in.mode),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cusd_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .o_data     (out_data),
        .i_ready    (o_out.ready)
    );

    assign o_out.value       = out_data.value;
    assign o_out.entry_bytes = out_data.entry_bytes;
    assign o_out.is_token    = out_data.is_token;
    assign o_out.tbl_code    = out_data.tbl_code;
    assign o_out.row_index   = out_data.row_index;

    // Properties of a decoded result.
    assign len_legal = (res.entry_bytes == LEN_ONE) || (res.entry_bytes == LEN_TWO) ||
                       (res.entry_bytes == LEN_FOUR);
    assign plain_ok  = res.is_token || ((res.tbl_code == TBL_NONE) && (res.row_index == '0));

    // Checks on the decode and buffering logic.
    `CUSD_ASSERT_NOW(a_stall_pending, i_clk, i_rst_n, !can_push, o_out.valid, "stall without result")
    `CUSD_ASSERT_NEXT(a_res_out, i_clk, i_rst_n, res_valid && !o_out.valid, o_out.valid, "result lost")
    `CUSD_ASSERT_NOW(a_entry_length, i_clk, i_rst_n, res_valid, len_legal, "bad entry length")
    `CUSD_ASSERT_NOW(a_plain_clear, i_clk, i_rst_n, res_valid, plain_ok, "token fields in plain mode")

endmodule

>>> test/cusd_checker.sv
module cusd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cusd_in_if                              i_bytes,
    cusd_out_if                             i_entries,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [cusd_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [cusd_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [cusd_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                            i_pready,
    output int                              o_pending,
    output int                              o_errors
);
    import cusd_pkg::*;

    // Mirror of the decoder's entry state and its one register.
    logic              ff_zero;
    logic [LEFT_W-1:0] left_count;
    logic [ACC_W-1:0]  partial_value;
    logic              entry_token;
    logic [LEN_W-1:0]  entry_len;

    // Decoded entries still owed by the block, oldest first.
    t_result pending_entries[$];

    // Build the full result of a completed entry, including the token split.
    function automatic t_result entry_result(input logic [VALUE_W-1:0] val,
                                             input logic [LEN_W-1:0] len,
                                             input logic tok);
        t_result r;
        r.value       = val;
        r.entry_bytes = len;
        r.is_token    = tok;
        r.tbl_code    = '0;
        r.row_index   = '0;
        if (tok) begin
            case (val[1:0])
                SEL_TYPEDEF:  r.tbl_code = TBL_TYPEDEF;
                SEL_TYPEREF:  r.tbl_code = TBL_TYPEREF;
                SEL_TYPESPEC: r.tbl_code = TBL_TYPESPEC;
                default:      r.tbl_code = TBL_NONE;
            endcase
            r.row_index = val[VALUE_W-1:2];
        end
        return r;
    endfunction

    // Advance the entry state by one accepted byte request.
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic m);
        logic [VALUE_W-1:0] esc_value;
        if (left_count == LEFT_NONE) begin
            if (!b[BYTE_W-1]) begin
                pending_entries.push_back(entry_result(VALUE_W'(b), LEN_ONE, m));
            end else if (b == ESCAPE_BYTE) begin
                // Token mode forces zero regardless of the register.
                esc_value = (m || ff_zero) ? '0 : '1;
                pending_entries.push_back(entry_result(esc_value, LEN_ONE, m));
            end else begin
                entry_token = m;
                if (b[7:6] == PREFIX_TWO) begin
                    partial_value = ACC_W'(b[5:0]);
                    left_count    = LEFT_ONE;
                    entry_len     = LEN_TWO;
                end else begin
                    // Both 110 and 111 prefixes start a four-byte entry.
                    partial_value = ACC_W'(b[4:0]);
                    left_count    = LEFT_THREE;
                    entry_len     = LEN_FOUR;
                end
            end
        end else begin
            partial_value = {partial_value[ACC_W-BYTE_W-1:0], b};
            left_count    = left_count - LEFT_ONE;
            if (left_count == LEFT_NONE) begin
                pending_entries.push_back(
                    entry_result(VALUE_W'(partial_value), entry_len, entry_token));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            ff_zero       = 1'b1;
            left_count    = LEFT_NONE;
            partial_value = '0;
            entry_token   = 1'b0;
            entry_len     = '0;
            pending_entries.delete();
            o_errors      = 0;
        end else begin
            if (i_bytes.valid && i_bytes.ready) begin
                decode_byte(i_bytes.byte_in, i_bytes.mode);
            end

            // Compare each delivered entry with the oldest prediction.
            if (i_entries.valid && i_entries.ready) begin
                got = '{value: i_entries.value, entry_bytes: i_entries.entry_bytes,
                        is_token: i_entries.is_token, tbl_code: i_entries.tbl_code,
                        row_index: i_entries.row_index};
                if (pending_entries.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected entry: expected none, got value %h",
                             $time, got.value);
                end else begin
                    want = pending_entries.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        $display("%0t: entry mismatch: expected %h/%0d/%b/%h/%h, got %h/%0d/%b/%h/%h",
                                 $time,
                                 want.value, want.entry_bytes, want.is_token,
                                 want.tbl_code, want.row_index,
                                 got.value, got.entry_bytes, got.is_token,
                                 got.tbl_code, got.row_index);
                    end
                end
            end

            // Track register writes and check register reads.
            if (i_psel && i_penable && i_pready) begin
                if (i_paddr[2] == REG_FF_GIVES_ZERO) begin
                    if (i_pwrite) begin
                        ff_zero = i_pwdata[0];
                    end else if (i_prdata !== APB_DATA_W'(ff_zero)) begin
                        o_errors++;
                        $display("%0t: register read: expected %h, got %h",
                                 $time, APB_DATA_W'(ff_zero), i_prdata);
                    end
                end
            end
        end
        o_pending = pending_entries.size();
    end

endmodule

>>> test/tb_compressed_uint_stream_decoder_core.sv
module tb_compressed_uint_stream_decoder_core;
    import cusd_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_FF_ZERO = {REG_FF_GIVES_ZERO, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED  = {~REG_FF_GIVES_ZERO, 2'b00};
    localparam int PHASE_BYTES = 267;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int pending;
    int errors;

    cusd_in_if  byte_bus();
    cusd_out_if entry_bus();

    compressed_uint_stream_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_bus),
        .o_out   (entry_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cusd_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bytes   (byte_bus),
        .i_entries (entry_bus),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_pending (pending),
        .o_errors  (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: random back-pressure, decided at each falling edge.
    initial entry_bus.ready = 1'b0;
    always @(negedge i_clk) begin
        entry_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one byte request and hold it until the decoder takes it.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic m);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            byte_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.byte_in <= b;
        byte_bus.mode    <= m;
        @(posedge i_clk);
        while (!byte_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and let every owed entry come out before touching the register.
    task automatic settle();
        byte_bus.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle.
    task automatic reg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Send one entry of a random kind, or one noise byte; returns the bytes sent.
    task automatic random_entry(output int sent);
        int kind;
        int len;
        logic [BYTE_W-1:0] rnd;
        logic [BYTE_W-1:0] first;
        kind = int'($urandom_range(9));
        rnd  = BYTE_W'($urandom);
        len  = 1;
        if (kind <= 2) begin
            first = {1'b0, rnd[6:0]};
        end else if (kind == 3) begin
            first = ESCAPE_BYTE;
        end else if (kind <= 5) begin
            first = {PREFIX_TWO, rnd[5:0]};
            len   = 2;
        end else if (kind <= 7) begin
            first = BYTE_W'($urandom_range(8'hFE, 8'hC0));
            len   = 4;
        end else begin
            // Plain noise: any byte, whatever state the decoder is in.
            first = rnd;
        end
        push_byte(first, 1'($urandom_range(1)));
        for (int k = 1; k < len; k++) begin
            push_byte(BYTE_W'($urandom), 1'($urandom_range(1)));
        end
        sent = len;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int total;
        int n;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        total = 0;
        while (total < PHASE_BYTES) begin
            random_entry(n);
            total += n;
        end
    endtask

    initial begin
        int guard;
        byte_bus.valid   = 1'b0;
        byte_bus.byte_in = '0;
        byte_bus.mode    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One-byte extremes, token table selectors and the escape byte.
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b1);
        push_byte(8'h01, 1'b1);
        push_byte(8'h02, 1'b1);
        push_byte(ESCAPE_BYTE, 1'b0);
        push_byte(ESCAPE_BYTE, 1'b1);

        // Two-byte extremes; mode on later bytes is the opposite and must be ignored.
        push_byte(8'h80, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hBF, 1'b1);
        push_byte(8'hFF, 1'b0);

        // Four-byte entries with both the 110 and the 111 prefix.
        push_byte(8'hC0, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFE, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hE0, 1'b0);
        push_byte(8'h12, 1'b1);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1);

        // Register write in the middle of an entry affects only later escapes.
        push_byte(8'hC1, 1'b1);
        settle();
        reg_access(1'b1, ADDR_FF_ZERO, 32'h0000_0000);
        reg_access(1'b0, ADDR_FF_ZERO, '0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(ESCAPE_BYTE, 1'b0);
        push_byte(ESCAPE_BYTE, 1'b1);

        run_phase(35, 77);

        // A write to an unused address leaves the escape decoding alone.
        settle();
        reg_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF);
        push_byte(ESCAPE_BYTE, 1'b0);
        settle();
        reg_access(1'b1, ADDR_FF_ZERO, 32'hFFFF_FFFF);
        reg_access(1'b0, ADDR_FF_ZERO, '0);

        run_phase(77, 35);

        settle();
        reg_access(1'b1, ADDR_FF_ZERO, 32'hFFFF_FFFE);
        reg_access(1'b0, ADDR_FF_ZERO, '0);

        run_phase(0, 0);

        // Drain, bounded so that a lost entry is seen as a leftover.
        byte_bus.valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
